/* design/rtht_pkg.sv */
// Package for the ray/triangle hit test: widths and register map.
`timescale 1ns / 1ps

package rtht_pkg;

    // Coordinate width on the common grid
    localparam int COORD_BITS = 16;

    // Difference of two coordinates
    localparam int DIFF_W  = COORD_BITS + 1;
    // One product term of a cross product
    localparam int XPROD_W = 2 * DIFF_W;
    // Cross product component
    localparam int CROSS_W = XPROD_W + 1;
    // One product term of a dot product
    localparam int DPROD_W = DIFF_W + CROSS_W;
    // Dot product (sum of three terms)
    localparam int DOT_W   = DPROD_W + 2;
    // Sum s + t
    localparam int SUM_W   = DOT_W + 1;

    // Pipeline depth from input register to output register
    localparam int NUM_STAGES = 6;

    // Stream payload widths
    localparam int S_DATA_W = 9 * COORD_BITS;
    localparam int S_TDATA_W = ((S_DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [XPROD_W-1:0]    xprod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [DPROD_W-1:0]    dprod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

endpackage

/* design/ray_triangle_hit_test.sv */
// Pipelined ray/triangle line hit test with an APB register port for the ray.
//
// The ray origin and direction sit in six APB registers (origin x/y/z at
// 0x00/0x04/0x08, direction x/y/z at 0x0C/0x10/0x14), written while no word
// is in flight. Triangles stream in on the s_ channel, one word per triangle
// holding the three vertices; the m_ channel returns one word per triangle
// whose bit 0 is the hit flag. Points on an edge or a vertex count as hits,
// and a zero determinant (parallel ray, degenerate triangle, zero direction)
// is a miss.
// A new triangle is taken every cycle while the output is not stalled; the
// throughput is one word per cycle. Each triangle passes six register stages
// (edges, cross terms, cross sums, dot terms, dot sums, compare) from the
// accepting edge to m_tvalid, each holding at most one multiplier per product.
// When m_tready is low, stages hold their words and bubbles collapse, so
// s_tready drops only once every stage is full. Reset clears all stage valid
// bits and sets the ray registers to zero.
`timescale 1ns / 1ps

module ray_triangle_hit_test
    import rtht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Triangle input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // low to high: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
    // vert_b_z, vert_c_x, vert_c_y, vert_c_z
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Hit result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // low to high: hit, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    coord_t   origin_reg [3];
    coord_t   dir_reg    [3];
    reg_idx_t cfg_idx;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[REG_IDX_W+1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ORIGIN_X: origin_reg[0] <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= pwdata[COORD_BITS-1:0];
                REG_DIR_X:    dir_reg[0]    <= pwdata[COORD_BITS-1:0];
                REG_DIR_Y:    dir_reg[1]    <= pwdata[COORD_BITS-1:0];
                REG_DIR_Z:    dir_reg[2]    <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ORIGIN_X: prdata = APB_DATA_W'(origin_reg[0]);
            REG_ORIGIN_Y: prdata = APB_DATA_W'(origin_reg[1]);
            REG_ORIGIN_Z: prdata = APB_DATA_W'(origin_reg[2]);
            REG_DIR_X:    prdata = APB_DATA_W'(dir_reg[0]);
            REG_DIR_Y:    prdata = APB_DATA_W'(dir_reg[1]);
            REG_DIR_Z:    prdata = APB_DATA_W'(dir_reg[2]);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage advances when it is empty or its
    // successor advances.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_ready;

    always_comb begin
        stage_ready[NUM_STAGES-1] = ~valid_reg[NUM_STAGES-1] | m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
        end
    end

    assign s_tready = stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: edges and origin offset
    // ------------------------------------------------------------------
    coord_t vert_a [3];
    coord_t vert_b [3];
    coord_t vert_c [3];
    diff_t  e1_next [3];
    diff_t  e2_next [3];
    diff_t  pv_next [3];
    diff_t  e1_s1_reg [3];
    diff_t  e2_s1_reg [3];
    diff_t  pv_s1_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vert_a[i]  = s_tdata[i*COORD_BITS +: COORD_BITS];
            vert_b[i]  = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
            vert_c[i]  = s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
            e1_next[i] = DIFF_W'(vert_b[i]) - DIFF_W'(vert_a[i]);
            e2_next[i] = DIFF_W'(vert_c[i]) - DIFF_W'(vert_a[i]);
            pv_next[i] = DIFF_W'(origin_reg[i]) - DIFF_W'(vert_a[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            e1_s1_reg <= e1_next;
            e2_s1_reg <= e2_next;
            pv_s1_reg <= pv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross product terms, ax = dir x e2 and q = pv x e1
    // ------------------------------------------------------------------
    diff_t  dir_ext [3];
    xprod_t axa_next [3];
    xprod_t axb_next [3];
    xprod_t qa_next  [3];
    xprod_t qb_next  [3];
    xprod_t axa_reg  [3];
    xprod_t axb_reg  [3];
    xprod_t qa_reg   [3];
    xprod_t qb_reg   [3];
    diff_t  e1_s2_reg [3];
    diff_t  pv_s2_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dir_ext[i] = DIFF_W'(dir_reg[i]);
        end
        axa_next[0] = XPROD_W'(dir_ext[1]) * XPROD_W'(e2_s1_reg[2]);
        axb_next[0] = XPROD_W'(dir_ext[2]) * XPROD_W'(e2_s1_reg[1]);
        axa_next[1] = XPROD_W'(dir_ext[2]) * XPROD_W'(e2_s1_reg[0]);
        axb_next[1] = XPROD_W'(dir_ext[0]) * XPROD_W'(e2_s1_reg[2]);
        axa_next[2] = XPROD_W'(dir_ext[0]) * XPROD_W'(e2_s1_reg[1]);
        axb_next[2] = XPROD_W'(dir_ext[1]) * XPROD_W'(e2_s1_reg[0]);
        qa_next[0]  = XPROD_W'(pv_s1_reg[1]) * XPROD_W'(e1_s1_reg[2]);
        qb_next[0]  = XPROD_W'(pv_s1_reg[2]) * XPROD_W'(e1_s1_reg[1]);
        qa_next[1]  = XPROD_W'(pv_s1_reg[2]) * XPROD_W'(e1_s1_reg[0]);
        qb_next[1]  = XPROD_W'(pv_s1_reg[0]) * XPROD_W'(e1_s1_reg[2]);
        qa_next[2]  = XPROD_W'(pv_s1_reg[0]) * XPROD_W'(e1_s1_reg[1]);
        qb_next[2]  = XPROD_W'(pv_s1_reg[1]) * XPROD_W'(e1_s1_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            axa_reg   <= axa_next;
            axb_reg   <= axb_next;
            qa_reg    <= qa_next;
            qb_reg    <= qb_next;
            e1_s2_reg <= e1_s1_reg;
            pv_s2_reg <= pv_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross product sums
    // ------------------------------------------------------------------
    cross_t ax_next [3];
    cross_t q_next  [3];
    cross_t ax_reg  [3];
    cross_t q_reg   [3];
    diff_t  e1_s3_reg [3];
    diff_t  pv_s3_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ax_next[i] = CROSS_W'(axa_reg[i]) - CROSS_W'(axb_reg[i]);
            q_next[i]  = CROSS_W'(qa_reg[i]) - CROSS_W'(qb_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            ax_reg    <= ax_next;
            q_reg     <= q_next;
            e1_s3_reg <= e1_s2_reg;
            pv_s3_reg <= pv_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dot product terms for det, s and t
    // ------------------------------------------------------------------
    dprod_t det_term_next [3];
    dprod_t s_term_next   [3];
    dprod_t t_term_next   [3];
    dprod_t det_term_reg  [3];
    dprod_t s_term_reg    [3];
    dprod_t t_term_reg    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            det_term_next[i] = DPROD_W'(e1_s3_reg[i]) * DPROD_W'(ax_reg[i]);
            s_term_next[i]   = DPROD_W'(pv_s3_reg[i]) * DPROD_W'(ax_reg[i]);
            t_term_next[i]   = DPROD_W'(dir_reg[i]) * DPROD_W'(q_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            det_term_reg <= det_term_next;
            s_term_reg   <= s_term_next;
            t_term_reg   <= t_term_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dot product sums
    // ------------------------------------------------------------------
    dot_t det_next;
    dot_t s_next;
    dot_t t_next;
    dot_t det_reg;
    dot_t s_reg;
    dot_t t_reg;

    always_comb begin
        det_next = DOT_W'(det_term_reg[0]) + DOT_W'(det_term_reg[1])
                 + DOT_W'(det_term_reg[2]);
        s_next   = DOT_W'(s_term_reg[0]) + DOT_W'(s_term_reg[1])
                 + DOT_W'(s_term_reg[2]);
        t_next   = DOT_W'(t_term_reg[0]) + DOT_W'(t_term_reg[1])
                 + DOT_W'(t_term_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            det_reg <= det_next;
            s_reg   <= s_next;
            t_reg   <= t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: inside test, mirrored for a negative determinant
    // ------------------------------------------------------------------
    sum_t det_ext;
    sum_t s_ext;
    sum_t st_sum;
    logic det_zero;
    logic det_neg;
    logic inside_pos;
    logic inside_neg;
    logic hit_next;
    logic hit_reg;

    always_comb begin
        det_ext  = SUM_W'(det_reg);
        s_ext    = SUM_W'(s_reg);
        st_sum   = s_ext + SUM_W'(t_reg);
        det_zero = (det_reg == '0);
        det_neg  = det_reg[DOT_W-1];
        inside_pos = ~s_reg[DOT_W-1] & ~(s_ext > det_ext)
                   & ~t_reg[DOT_W-1] & ~(st_sum > det_ext);
        inside_neg = ~(s_reg > dot_t'(0)) & ~(s_ext < det_ext)
                   & ~(t_reg > dot_t'(0)) & ~(st_sum < det_ext);
        hit_next = ~det_zero & (det_neg ? inside_neg : inside_pos);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, hit_reg};

endmodule
